// ===== rtl/tgcm_pkg.sv =====
// Shared types and constants of the trajectory grid cell mapper.
`default_nettype none

package tgcm_pkg;

    // Fixed field widths.
    localparam int COORD_W     = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [CFG_W-1:0] INV_RESET = 32'h0001_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_INV_W    = 2'd2,
        CFG_INV_H    = 2'd3
    } t_cfg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [CFG_W-1:0] origin_x;
        logic [CFG_W-1:0] origin_y;
        logic [CFG_W-1:0] inv_w;
        logic [CFG_W-1:0] inv_h;
    } t_cfg;

    // Handoff from the quantizer to the cell walker.
    typedef struct packed {
        logic start;
        logic starts_track;
        logic clamp;
    } t_walk_req;

endpackage

`default_nettype wire

// ===== rtl/tgcm_if.sv =====
// Channel interfaces for trajectory points and emitted grid cells.
`default_nettype none

interface tgcm_point_if import tgcm_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      starts_track;

    modport source (output valid, output point_x, output point_y, output starts_track,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input starts_track,
                    output ready);
endinterface

interface tgcm_cell_if import tgcm_pkg::*; #(
    parameter int GRID_CELLS = 32
);
    localparam int IDX_W = $clog2(GRID_CELLS + 1);

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] cell_col;
    logic [IDX_W-1:0] cell_row;
    logic [POS_W-1:0] seq_pos;
    logic             is_fill;
    logic             was_clamped;
    logic             last_of_run;

    modport source (output valid, output cell_col, output cell_row, output seq_pos,
                    output is_fill, output was_clamped, output last_of_run, input ready);
    modport sink   (input valid, input cell_col, input cell_row, input seq_pos,
                    input is_fill, input was_clamped, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgcm_quant.sv =====
// Quantizer: one shared 32x32 multiplier maps both coordinates to grid indexes.
`default_nettype none

module tgcm_quant import tgcm_pkg::*; #(
    parameter int GRID_CELLS = 32,
    localparam int IDX_W = $clog2(GRID_CELLS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic                      i_starts_track,
    output logic                      o_busy,
    output t_walk_req                 o_req,
    output logic [IDX_W-1:0]          o_col,
    output logic [IDX_W-1:0]          o_row
);

    typedef enum logic [3:0] {
        Q_IDLE = 4'b0001,
        Q_MULX = 4'b0010,
        Q_MULY = 4'b0100,
        Q_RNDY = 4'b1000
    } t_qstate;

    t_qstate r_state, n_state;

    logic [COORD_W-1:0]   r_mag_x, r_mag_y;
    logic                 r_neg_x, r_neg_y;
    logic [2*COORD_W-1:0] r_prod;
    logic [IDX_W-1:0]     r_col, r_row;
    logic                 r_clamp;
    logic                 r_st;
    logic                 r_done;

    logic [COORD_W:0]   dx_fwd, dx_bwd, dy_fwd, dy_bwd;
    logic [COORD_W:0]   rnd_q;
    logic               rnd_neg;
    logic [IDX_W-1:0]   rnd_idx;
    logic               rnd_clamp;
    logic [COORD_W-1:0] mul_a, mul_b;

    // Difference from the origin in both directions; the sign picks the magnitude.
    assign dx_fwd = {i_point_x[COORD_W-1], i_point_x}
                  - {i_cfg.origin_x[COORD_W-1], i_cfg.origin_x};
    assign dx_bwd = {i_cfg.origin_x[COORD_W-1], i_cfg.origin_x}
                  - {i_point_x[COORD_W-1], i_point_x};
    assign dy_fwd = {i_point_y[COORD_W-1], i_point_y}
                  - {i_cfg.origin_y[COORD_W-1], i_cfg.origin_y};
    assign dy_bwd = {i_cfg.origin_y[COORD_W-1], i_cfg.origin_y}
                  - {i_point_y[COORD_W-1], i_point_y};

    // Shared multiplier operands: x in the first pass, y in the second.
    assign mul_a = (r_state == Q_MULX) ? r_mag_x : r_mag_y;
    assign mul_b = (r_state == Q_MULX) ? i_cfg.inv_w : i_cfg.inv_h;

    // Round half away from zero, then saturate to the grid.
    assign rnd_neg = (r_state == Q_MULY) ? r_neg_x : r_neg_y;
    assign rnd_q   = {1'b0, r_prod[2*COORD_W-1:COORD_W]} + (COORD_W+1)'(r_prod[COORD_W-1]);

    always_comb begin
        rnd_idx   = rnd_q[IDX_W-1:0];
        rnd_clamp = 1'b0;
        if (rnd_neg) begin
            rnd_idx   = '0;
            rnd_clamp = (rnd_q != '0);
        end else if (rnd_q > (COORD_W+1)'(GRID_CELLS)) begin
            rnd_idx   = IDX_W'(GRID_CELLS);
            rnd_clamp = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE: begin
                if (i_start) n_state = Q_MULX;
            end
            Q_MULX: n_state = Q_MULY;
            Q_MULY: n_state = Q_RNDY;
            Q_RNDY: n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == Q_RNDY);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == Q_IDLE && i_start) begin
            r_neg_x <= dx_fwd[COORD_W];
            r_mag_x <= dx_fwd[COORD_W] ? dx_bwd[COORD_W-1:0] : dx_fwd[COORD_W-1:0];
            r_neg_y <= dy_fwd[COORD_W];
            r_mag_y <= dy_fwd[COORD_W] ? dy_bwd[COORD_W-1:0] : dy_fwd[COORD_W-1:0];
            r_st    <= i_starts_track;
        end
        if (r_state == Q_MULX || r_state == Q_MULY) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == Q_MULY) begin
            r_col   <= rnd_idx;
            r_clamp <= rnd_clamp;
        end
        if (r_state == Q_RNDY) begin
            r_row   <= rnd_idx;
            r_clamp <= r_clamp | rnd_clamp;
        end
    end

    assign o_busy             = (r_state != Q_IDLE) || r_done;
    assign o_req.start        = r_done;
    assign o_req.starts_track = r_st;
    assign o_req.clamp        = r_clamp;
    assign o_col              = r_col;
    assign o_row              = r_row;

endmodule

`default_nettype wire

// ===== rtl/tgcm_walk.sv =====
// Cell walker: gap filling by midpoint subdivision on a span stack, and the result register.
`default_nettype none

module tgcm_walk import tgcm_pkg::*; #(
    parameter int GRID_CELLS  = 32,
    parameter int STACK_DEPTH = 6,
    localparam int IDX_W = $clog2(GRID_CELLS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_walk_req        i_req,
    input  logic [IDX_W-1:0] i_col,
    input  logic [IDX_W-1:0] i_row,
    output logic             o_busy,
    tgcm_cell_if.source      o_cell
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int ENT_W  = 4 * IDX_W;
    localparam logic [IDX_W:0] D_ONE  = (IDX_W+1)'(1);
    localparam logic [IDX_W:0] D_MONE = '1;

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_FILL = 3'b010,
        W_OWN  = 3'b100
    } t_wstate;

    // True when two cells are equal or 8-neighbors.
    function automatic logic near(input logic [IDX_W-1:0] c1, input logic [IDX_W-1:0] r1,
                                  input logic [IDX_W-1:0] c2, input logic [IDX_W-1:0] r2);
        logic [IDX_W:0] dc;
        logic [IDX_W:0] dr;
        dc = {1'b0, c1} - {1'b0, c2};
        dr = {1'b0, r1} - {1'b0, r2};
        return (dc == '0 || dc == D_ONE || dc == D_MONE) &&
               (dr == '0 || dr == D_ONE || dr == D_MONE);
    endfunction

    t_wstate r_state, n_state;

    logic [ENT_W-1:0] r_stack [STACK_DEPTH];
    logic [LVL_W-1:0] r_level;
    logic [CNT_W-1:0] r_n;
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] r_prev_c, r_prev_r;
    logic [IDX_W-1:0] r_c, r_r;
    logic             r_clamp;
    logic [IDX_W-1:0] r_sc, r_sr, r_ec, r_er;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_col, r_out_row;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_fill, r_out_clamp, r_out_last;

    logic [IDX_W:0]    sum_c, sum_r;
    logic [IDX_W-1:0]  mid_c, mid_r;
    logic              span_near, can_push, fill_end, out_free;
    logic              do_start, do_push, do_pop, do_own;
    logic [LVL_W-1:0]  lvl_dec;
    logic [SIDX_W-1:0] top_idx;
    logic [ENT_W-1:0]  top_ent;
    logic [POS_W-1:0]  pos_inc;
    logic              start_near, same_cell;

    // Midpoint of the current span, rounding halves up.
    assign sum_c = {1'b0, r_sc} + {1'b0, r_ec} + (IDX_W+1)'(1);
    assign sum_r = {1'b0, r_sr} + {1'b0, r_er} + (IDX_W+1)'(1);
    assign mid_c = sum_c[IDX_W:1];
    assign mid_r = sum_r[IDX_W:1];

    // Stack control.
    assign span_near = near(r_sc, r_sr, r_ec, r_er);
    assign can_push  = !span_near && (r_level < LVL_W'(STACK_DEPTH));
    assign fill_end  = (r_level == '0) || (r_n >= CNT_W'(MAX_RESULTS - 1));
    assign lvl_dec   = r_level - LVL_W'(1);
    assign top_idx   = lvl_dec[SIDX_W-1:0];
    assign top_ent   = r_stack[top_idx];
    assign out_free  = !r_out_valid || o_cell.ready;
    assign pos_inc   = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);

    assign start_near = near(r_prev_c, r_prev_r, i_col, i_row);
    assign same_cell  = (r_prev_c == i_col) && (r_prev_r == i_row);

    assign do_start = (r_state == W_IDLE) && i_req.start;
    assign do_push  = (r_state == W_FILL) && can_push;
    assign do_pop   = (r_state == W_FILL) && !can_push && !fill_end && out_free;
    assign do_own   = (r_state == W_OWN) && out_free;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            W_IDLE: begin
                if (i_req.start) begin
                    if (i_req.starts_track) n_state = W_OWN;
                    else if (!start_near)   n_state = W_FILL;
                    else if (!same_cell)    n_state = W_OWN;
                end
            end
            W_FILL: begin
                if (!can_push && fill_end) n_state = W_OWN;
            end
            W_OWN: begin
                if (out_free) n_state = W_IDLE;
            end
            default: n_state = W_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= W_IDLE;
            r_level     <= '0;
            r_n         <= '0;
            r_pos       <= '0;
            r_prev_c    <= '0;
            r_prev_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_start) begin
                r_prev_c <= i_col;
                r_prev_r <= i_row;
                r_level  <= '0;
                r_n      <= '0;
                if (i_req.starts_track) r_pos <= '0;
            end
            if (do_push) r_level <= r_level + LVL_W'(1);
            if (do_pop) begin
                r_level <= lvl_dec;
                r_n     <= r_n + CNT_W'(1);
            end
            if (do_pop || do_own) begin
                r_pos       <= pos_inc;
                r_out_valid <= 1'b1;
            end else if (o_cell.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Span, stack and result payload.
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_c     <= i_col;
            r_r     <= i_row;
            r_clamp <= i_req.clamp;
            r_sc    <= r_prev_c;
            r_sr    <= r_prev_r;
            r_ec    <= i_col;
            r_er    <= i_row;
        end
        if (do_push) begin
            r_stack[r_level[SIDX_W-1:0]] <= {mid_c, mid_r, r_ec, r_er};
            r_ec <= mid_c;
            r_er <= mid_r;
        end
        if (do_pop) begin
            {r_sc, r_sr, r_ec, r_er} <= top_ent;
            r_out_col   <= top_ent[ENT_W-1 -: IDX_W];
            r_out_row   <= top_ent[ENT_W-IDX_W-1 -: IDX_W];
            r_out_pos   <= r_pos;
            r_out_fill  <= 1'b1;
            r_out_clamp <= r_clamp;
            r_out_last  <= 1'b0;
        end
        if (do_own) begin
            r_out_col   <= r_c;
            r_out_row   <= r_r;
            r_out_pos   <= r_pos;
            r_out_fill  <= 1'b0;
            r_out_clamp <= r_clamp;
            r_out_last  <= 1'b1;
        end
    end

    assign o_busy             = (r_state != W_IDLE);
    assign o_cell.valid       = r_out_valid;
    assign o_cell.cell_col    = r_out_col;
    assign o_cell.cell_row    = r_out_row;
    assign o_cell.seq_pos     = r_out_pos;
    assign o_cell.is_fill     = r_out_fill;
    assign o_cell.was_clamped = r_out_clamp;
    assign o_cell.last_of_run = r_out_last;

    // The stack never grows past its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(STACK_DEPTH))
        else $error("span stack level above its depth");

    // Fill cells are always followed by the point's own cell.
    a_fill_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fill) |-> !r_out_last)
        else $error("fill cell marked as last of run");

    // Emitted cells lie inside the grid.
    a_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_col <= IDX_W'(GRID_CELLS) && r_out_row <= IDX_W'(GRID_CELLS)))
        else $error("emitted cell outside the grid");

    // Fill count per point leaves room for the point's own cell.
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_RESULTS - 1))
        else $error("too many fill cells for one point");

endmodule

`default_nettype wire

// ===== rtl/trajectory_grid_cell_mapper.sv =====
// A point is quantized through states Q_MULX, Q_MULY and Q_RNDY and handed to the cell
// walker by the registered done strobe; the walker's W_OWN state then loads its own cell
// into the result register. A new point is taken only once the previous one has left both
// the quantizer and the walker; gap filling (span-stack pushes and pops) and any wait on
// the result side hold it longer.
// Reset (synchronous, active low) sets origins to 0, reciprocals to 1.0, previous cell to
// (0,0), position to 0 and empties the stack and result register; no clearing pass.
`default_nettype none

module trajectory_grid_cell_mapper import tgcm_pkg::*; #(
    parameter int GRID_CELLS  = 32,
    parameter int STACK_DEPTH = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tgcm_point_if.sink           i_pt,
    tgcm_cell_if.source          o_cell
);

    localparam int IDX_W = $clog2(GRID_CELLS + 1);

    t_cfg             r_cfg;
    t_walk_req        q_req;
    logic [IDX_W-1:0] q_col, q_row;
    logic             q_busy, w_busy;
    logic             pt_accept;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.inv_w    <= INV_RESET;
            r_cfg.inv_h    <= INV_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data;
                CFG_INV_W:    r_cfg.inv_w    <= i_cfg_data;
                CFG_INV_H:    r_cfg.inv_h    <= i_cfg_data;
            endcase
        end
    end

    // A point transaction is taken only when both units are free.
    assign i_pt.ready = !q_busy && !w_busy;
    assign pt_accept  = i_pt.valid && i_pt.ready;

    tgcm_quant #(
        .GRID_CELLS (GRID_CELLS)
    ) u_quant (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (pt_accept),
        .i_point_x      (i_pt.point_x),
        .i_point_y      (i_pt.point_y),
        .i_starts_track (i_pt.starts_track),
        .o_busy         (q_busy),
        .o_req          (q_req),
        .o_col          (q_col),
        .o_row          (q_row)
    );

    tgcm_walk #(
        .GRID_CELLS  (GRID_CELLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .i_col   (q_col),
        .i_row   (q_row),
        .o_busy  (w_busy),
        .o_cell  (o_cell)
    );

endmodule

`default_nettype wire

// ===== sim/trajectory_grid_cell_mapper_tb.sv =====
// Self-checking testbench for the trajectory grid cell mapper: directed and random tracks.
`timescale 1ns / 1ps

module trajectory_grid_cell_mapper_tb import tgcm_pkg::*;;

    localparam int GRID_CELLS  = 32;
    localparam int STACK_DEPTH = 6;
    localparam int Q           = 65536;   // 1.0 in Q16.16
    localparam int SETTLE      = 20;      // quiet cycles before touching registers

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               starts;
    } t_point;

    typedef struct packed {
        logic [5:0]       col;
        logic [5:0]       row;
        logic [POS_W-1:0] pos;
        logic             fill;
        logic             clamped;
        logic             last;
    } t_cell;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    tgcm_point_if pt_if ();
    tgcm_cell_if #(.GRID_CELLS(GRID_CELLS)) cell_if ();

    trajectory_grid_cell_mapper #(
        .GRID_CELLS (GRID_CELLS),
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_cell     (cell_if)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the register file.
    logic [CFG_W-1:0] cfg_origin_x = '0;
    logic [CFG_W-1:0] cfg_origin_y = '0;
    logic [CFG_W-1:0] cfg_inv_w    = INV_RESET;
    logic [CFG_W-1:0] cfg_inv_h    = INV_RESET;

    // Shadow copy of the mapper state.
    int unsigned      last_col  = 0;
    int unsigned      last_row  = 0;
    logic [POS_W-1:0] track_pos = '0;

    t_point pending_points[$];
    t_cell  expected_cells[$];
    t_point next_point;
    int     points_queued  = 0;
    int     points_taken   = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     mismatch_count = 0;
    logic   pt_taken       = 1'b0;

    // Rounds (coordinate - origin) * reciprocal to a grid index and saturates it.
    function automatic int unsigned grid_index(input logic [31:0] coord,
                                               input logic [31:0] org,
                                               input logic [31:0] inv,
                                               output bit out_of_grid);
        longint     diff;
        logic [63:0] mag;
        logic [63:0] rounded;
        out_of_grid = 1'b0;
        diff = longint'($signed(coord)) - longint'($signed(org));
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        rounded = (mag * {32'd0, inv} + 64'h8000_0000) >> 32;
        if (diff < 0) begin
            out_of_grid = (rounded != 0);
            return 0;
        end
        if (rounded > GRID_CELLS) begin
            out_of_grid = 1'b1;
            return GRID_CELLS;
        end
        return rounded[31:0];
    endfunction

    function automatic bit is_adjacent(int unsigned c1, int unsigned r1,
                                       int unsigned c2, int unsigned r2);
        int dc;
        int dr;
        dc = int'(c1) - int'(c2);
        dr = int'(r1) - int'(r2);
        return dc >= -1 && dc <= 1 && dr >= -1 && dr <= 1;
    endfunction

    // Builds one emitted cell and advances the saturating track position.
    function automatic t_cell make_cell(int unsigned c, int unsigned r, bit fill, bit clamped);
        t_cell entry;
        entry.col     = c[5:0];
        entry.row     = r[5:0];
        entry.pos     = track_pos;
        entry.fill    = fill;
        entry.clamped = clamped;
        entry.last    = 1'b0;
        if (track_pos != POS_MAX) track_pos++;
        return entry;
    endfunction

    // Computes every cell that one accepted point emits, gap fill first.
    function automatic void predict_cells(t_point pt);
        bit          clamp_c;
        bit          clamp_r;
        bit          clamped;
        int unsigned col;
        int unsigned row;
        int unsigned sc;
        int unsigned sr;
        int unsigned ec;
        int unsigned er;
        int unsigned mc;
        int unsigned mr;
        int unsigned lvl;
        int unsigned span_sc[STACK_DEPTH];
        int unsigned span_sr[STACK_DEPTH];
        int unsigned span_ec[STACK_DEPTH];
        int unsigned span_er[STACK_DEPTH];
        t_cell       run[$];
        t_cell       tail;
        col = grid_index(pt.x, cfg_origin_x, cfg_inv_w, clamp_c);
        row = grid_index(pt.y, cfg_origin_y, cfg_inv_h, clamp_r);
        clamped = clamp_c | clamp_r;
        if (pt.starts) begin
            track_pos = '0;
            run.push_back(make_cell(col, row, 1'b0, clamped));
        end else begin
            if (!is_adjacent(last_col, last_row, col, row)) begin
                sc = last_col;
                sr = last_row;
                ec = col;
                er = row;
                lvl = 0;
                // Midpoint subdivision: push the far half, walk into the near half.
                while (1) begin
                    if (!is_adjacent(sc, sr, ec, er) && lvl < STACK_DEPTH) begin
                        mc = (sc + ec + 1) >> 1;
                        mr = (sr + er + 1) >> 1;
                        span_sc[lvl] = mc;
                        span_sr[lvl] = mr;
                        span_ec[lvl] = ec;
                        span_er[lvl] = er;
                        lvl++;
                        ec = mc;
                        er = mr;
                    end else if (lvl == 0 || run.size() >= MAX_RESULTS - 1) begin
                        break;
                    end else begin
                        lvl--;
                        sc = span_sc[lvl];
                        sr = span_sr[lvl];
                        ec = span_ec[lvl];
                        er = span_er[lvl];
                        run.push_back(make_cell(sc, sr, 1'b1, clamped));
                    end
                end
            end
            if (col != last_col || row != last_row)
                run.push_back(make_cell(col, row, 1'b0, clamped));
        end
        last_col = col;
        last_row = row;
        if (run.size() != 0) begin
            tail = run.pop_back();
            tail.last = 1'b1;
            run.push_back(tail);
        end
        foreach (run[i]) expected_cells.push_back(run[i]);
    endfunction

    // Point driver and result-side backpressure, both changing on the falling edge.
    always @(negedge i_clk) begin
        cell_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || pt_taken) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_point = pending_points.pop_front();
                pt_if.point_x      <= next_point.x;
                pt_if.point_y      <= next_point.y;
                pt_if.starts_track <= next_point.starts;
                pt_if.valid        <= 1'b1;
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each point transaction, check each cell transaction.
    always @(posedge i_clk) begin
        t_cell got;
        t_cell want;
        pt_taken <= i_rst_n && pt_if.valid && pt_if.ready;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            predict_cells('{x: pt_if.point_x, y: pt_if.point_y, starts: pt_if.starts_track});
            points_taken++;
        end
        if (i_rst_n && cell_if.valid && cell_if.ready) begin
            got = '{col: cell_if.cell_col, row: cell_if.cell_row, pos: cell_if.seq_pos,
                    fill: cell_if.is_fill, clamped: cell_if.was_clamped,
                    last: cell_if.last_of_run};
            if (expected_cells.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected cell, expected none, got col %0d row %0d pos %0d",
                         $realtime, got.col, got.row, got.pos);
            end else begin
                want = expected_cells.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    $display({"%0t: cell mismatch, expected col %0d row %0d pos %0d fill %0b",
                              " clamp %0b last %0b, got col %0d row %0d pos %0d fill %0b",
                              " clamp %0b last %0b"}, $realtime,
                             want.col, want.row, want.pos, want.fill, want.clamped, want.last,
                             got.col, got.row, got.pos, got.fill, got.clamped, got.last);
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: cfg_origin_x = value;
            CFG_ORIGIN_Y: cfg_origin_y = value;
            CFG_INV_W:    cfg_inv_w    = value;
            CFG_INV_H:    cfg_inv_h    = value;
        endcase
    endtask

    function automatic t_point make_point(logic [31:0] x, logic [31:0] y, bit starts);
        t_point p;
        p.x = x;
        p.y = y;
        p.starts = starts;
        return p;
    endfunction

    function automatic void push_point(t_point p);
        pending_points.push_back(p);
        points_queued++;
    endfunction

    // Random position in cell units (Q16.16), a little beyond the grid on both sides.
    function automatic longint rand_cell_pos();
        return longint'($urandom_range(0, 39 * Q)) - 3 * Q;
    endfunction

    // Converts a position in cell units back to a coordinate for the current setting.
    function automatic logic [31:0] to_coord(longint v, logic [31:0] org, logic [31:0] inv);
        if (inv == 0) return $urandom;
        return org + 32'((v <<< 16) / longint'(inv));
    endfunction

    function automatic longint clip_pos(longint v);
        if (v < -3 * Q) return -3 * Q;
        if (v > 36 * Q) return 36 * Q;
        return v;
    endfunction

    // Random trajectories: mostly short steps, with jumps, repeats, restarts and noise.
    function automatic void queue_tracks(int n_points);
        longint pos_c;
        longint pos_r;
        int     roll;
        t_point p;
        pos_c = 0;
        pos_r = 0;
        for (int i = 0; i < n_points; i++) begin
            roll = $urandom_range(99);
            p.starts = 1'b0;
            if (i == 0 || roll < 8) begin
                p.starts = 1'b1;
                pos_c = rand_cell_pos();
                pos_r = rand_cell_pos();
            end else if (roll < 22) begin
                pos_c = rand_cell_pos();
                pos_r = rand_cell_pos();
            end else if (roll >= 32) begin
                pos_c = clip_pos(pos_c + longint'($urandom_range(0, 209715)) - 104858);
                pos_r = clip_pos(pos_r + longint'($urandom_range(0, 209715)) - 104858);
            end
            p.x = to_coord(pos_c, cfg_origin_x, cfg_inv_w);
            p.y = to_coord(pos_r, cfg_origin_y, cfg_inv_h);
            if (roll >= 94) begin
                p.x = $urandom;
                p.y = $urandom;
                p.starts = $urandom_range(1);
            end
            push_point(p);
        end
    endfunction

    // Waits until every point is taken and every cell has come out, then lets it settle.
    task automatic wait_idle();
        while (points_taken != points_queued || expected_cells.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] iw,
                             logic [31:0] ih, int send_pct, int recv_pct, int n_points);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_INV_W, iw);
        write_reg(CFG_INV_H, ih);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_tracks(n_points);
        wait_idle();
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = CFG_ORIGIN_X;
        i_cfg_data         = '0;
        pt_if.valid        = 1'b0;
        pt_if.point_x      = '0;
        pt_if.point_y      = '0;
        pt_if.starts_track = 1'b0;
        cell_if.ready      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points at the reset setting: origin 0, one cell per unit.
        push_point(make_point(0, 0, 0));                   // no track yet, same cell
        push_point(make_point(2 * Q, 0, 0));               // one-cell gap
        push_point(make_point(Q, Q, 0));                   // neighbor
        push_point(make_point(32 * Q, 32 * Q, 0));         // long diagonal gap
        push_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0)); // saturates onto same cell
        push_point(make_point(-32768, 0, 0));              // exactly -0.5 counts as clamped
        push_point(make_point(-32767, Q + Q / 2, 0));      // rounds to 0; half rounds up
        push_point(make_point(32'h8000_0000, 32'h8000_0000, 1));
        push_point(make_point(2 * Q + Q / 2, 2 * Q + Q / 2, 0));
        push_point(make_point(-5 * Q / 2, 5 * Q, 0));
        push_point(make_point(20 * Q, 5 * Q, 1));          // new track far away, no fill
        push_point(make_point(20 * Q, 5 * Q, 1));          // new track in the same cell
        push_point(make_point(21 * Q, 6 * Q, 0));
        push_point(make_point(5 * Q, 30 * Q, 0));
        push_point(make_point(32'hFFFF_FFFF, 1, 0));
        push_point(make_point(32 * Q, 0, 0));
        push_point(make_point(0, 32 * Q, 0));
        push_point(make_point(32 * Q + Q / 2, 31 * Q + Q / 2 - 1, 0));
        push_point(make_point(0, 0, 1));
        push_point(make_point(32 * Q, 32 * Q, 0));
        push_point(make_point(32 * Q, 0, 0));
        wait_idle();

        // Random phases across settings and flow-control patterns.
        run_phase(-344064, 3 * Q, 2 * Q, Q / 2, 0, 0, 110);
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 84, 0, 80);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 84, 80);
        run_phase($urandom, $urandom, $urandom_range(Q / 4, 4 * Q),
                  $urandom_range(Q / 4, 4 * Q), 30, 30, 100);
        run_phase($urandom, $urandom, $urandom_range(Q / 4, 4 * Q),
                  $urandom_range(Q / 4, 4 * Q), 30, 30, 60);

        // Short track bouncing corner to corner: every point after the first fills a full diagonal gap.
        write_reg(CFG_ORIGIN_X, '0);
        write_reg(CFG_ORIGIN_Y, '0);
        write_reg(CFG_INV_W, INV_RESET);
        write_reg(CFG_INV_H, INV_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_point(make_point(0, 0, 1));
        for (int i = 0; i < 19; i++) begin
            if (i % 2 == 0) push_point(make_point(32 * Q, 32 * Q, 0));
            else push_point(make_point(0, 0, 0));
        end
        wait_idle();

        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
